/* design/txrbds_pkg.sv */
// ----------------------------------------------------------------------------
// txrbds_pkg
// Shared types and codes of the transmit ring DMA segmenter.
// ----------------------------------------------------------------------------
package txrbds_pkg;

  localparam int FETCH_SPAN = 256;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_in;
    logic [7:0] fetch_index;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       full_res;
    logic       segment_started;
    logic [7:0] segment_start;
    logic [8:0] segment_length;
    logic       dma_busy;
    logic [7:0] fetch_byte;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic read;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic is_fetch;
  } status_t;

endpackage

/* design/tx_ring_buffer_dma_segmenter.sv */
// ----------------------------------------------------------------------------
// tx_ring_buffer_dma_segmenter
// Transmit byte ring that hands a DMA engine contiguous segments.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   txrbds_pkg::in_item_t
//   out      output     out_valid / out_stall txrbds_pkg::out_item_t
//
// put, done and unused kinds are captured, then executed into the output
// register; a fetch also passes through the store's read register first.
// one transaction is in work at a time; while a finished result waits in the
// output register the next transaction is captured and holds until it frees.
// rst clears the pointers, the segment length and the handshake flags; the
// byte store is not cleared.
// ----------------------------------------------------------------------------
module tx_ring_buffer_dma_segmenter #(
  parameter int DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  txrbds_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output txrbds_pkg::out_item_t out_item
);
  import txrbds_pkg::*;

  cmd_t    cmd;
  status_t status;

  txrbds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .status   (status)
  );

  txrbds_dpath #(
    .DEPTH(DEPTH)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_item),
    .cmd     (cmd),
    .status  (status),
    .out_item(out_item)
  );

endmodule

/* design/txrbds_ram.sv */
// ----------------------------------------------------------------------------
// txrbds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module txrbds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/txrbds_ctrl.sv */
// ----------------------------------------------------------------------------
// txrbds_ctrl
// Sequencer: takes one transaction, executes it, loads the output register.
// ----------------------------------------------------------------------------
module txrbds_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output txrbds_pkg::cmd_t    cmd,
  input  txrbds_pkg::status_t status
);
  import txrbds_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != ST_IDLE;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.read    = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.is_fetch) begin
          cmd.read   = 1'b1;
          state_next = ST_READ;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/txrbds_dpath.sv */
// ----------------------------------------------------------------------------
// txrbds_dpath
// Ring pointers, segment tracking, byte store and output register.
// ----------------------------------------------------------------------------
module txrbds_dpath #(
  parameter int DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  txrbds_pkg::in_item_t  in_item,
  input  txrbds_pkg::cmd_t      cmd,
  output txrbds_pkg::status_t   status,
  output txrbds_pkg::out_item_t out_item
);
  import txrbds_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  in_item_t       item;
  logic [AW-1:0]  head;
  logic [AW-1:0]  tail;
  logic [LW-1:0]  inflight;

  logic [AW-1:0]  head_next;
  logic [AW-1:0]  tail_next;
  logic [LW-1:0]  inflight_next;
  logic [AW-1:0]  tail_adv;
  logic           put_ok;
  logic           accepted;
  logic           started;
  logic           launch;
  logic [AW-1:0]  start_idx;
  logic [SW-1:0]  sum;
  logic           full;
  logic           ram_we;
  logic [AW-1:0]  fetch_map [FETCH_SPAN];
  logic [7:0]     rdata;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    ring_next = (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  for (genvar g = 0; g < FETCH_SPAN; g++) begin : g_fetch_map
    assign fetch_map[g] = AW'(g % DEPTH);
  end

  assign status.is_fetch = item.kind == KIND_FETCH;
  assign tail_adv        = ring_next(tail);
  assign put_ok          = tail_adv != head;
  assign sum             = SW'(head) + SW'(inflight);

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    inflight_next = inflight;
    accepted      = 1'b0;
    started       = 1'b0;
    launch        = 1'b0;
    start_idx     = '0;
    case (item.kind)
      KIND_PUT: begin
        if (put_ok) begin
          tail_next = tail_adv;
          accepted  = 1'b1;
          launch    = inflight == '0;
        end
      end
      KIND_DONE: begin
        head_next = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);
        launch    = 1'b1;
      end
      default: begin
      end
    endcase
    if (launch) begin
      if (head_next == tail_next) begin
        inflight_next = '0;
      end else begin
        started   = 1'b1;
        start_idx = head_next;
        if (tail_next < head_next) begin
          inflight_next = LW'(DEPTH) - LW'(head_next);
        end else begin
          inflight_next = LW'(tail_next) - LW'(head_next);
        end
      end
    end
  end

  assign full   = ring_next(tail_next) == head_next;
  assign ram_we = cmd.commit && (item.kind == KIND_PUT) && put_ok;

  txrbds_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail),
    .wdata(item.byte_in),
    .re   (cmd.read),
    .raddr(fetch_map[item.fetch_index]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_item;
    end
    if (cmd.commit) begin
      out_item.accepted        <= accepted;
      out_item.full_res        <= full;
      out_item.segment_started <= started;
      out_item.segment_start   <= 8'(start_idx);
      out_item.segment_length  <= 9'(inflight_next);
      out_item.dma_busy        <= inflight_next != '0;
      out_item.fetch_byte      <= (item.kind == KIND_FETCH) ? rdata : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      inflight <= '0;
    end else if (cmd.commit) begin
      head     <= head_next;
      tail     <= tail_next;
      inflight <= inflight_next;
    end
  end

endmodule
